// ===== src/dq_pkg.sv =====
// Shared types, codes and the control store for the bounded deque with search.
`default_nettype none
package dq_pkg;

  // Command codes of an input transaction.
  localparam logic [2:0] CMD_PUSH_TAIL = 3'd0;
  localparam logic [2:0] CMD_POP_TAIL  = 3'd1;
  localparam logic [2:0] CMD_PUSH_HEAD = 3'd2;
  localparam logic [2:0] CMD_POP_HEAD  = 3'd3;
  localparam logic [2:0] CMD_FIND      = 3'd4;

  // Status codes of a result transaction.
  localparam logic [2:0] ST_DONE  = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_FOUND = 3'd3;
  localparam logic [2:0] ST_MISS  = 3'd4;

  localparam int UPC_W = 4;

  // Datapath operations selected by a control word.
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_CLEAR     = 4'd1;
  localparam logic [3:0] OP_PUSH_TAIL = 4'd2;
  localparam logic [3:0] OP_PUSH_HEAD = 4'd3;
  localparam logic [3:0] OP_READ_TAIL = 4'd4;
  localparam logic [3:0] OP_READ_HEAD = 4'd5;
  localparam logic [3:0] OP_TAKE      = 4'd6;
  localparam logic [3:0] OP_SCAN      = 4'd7;
  localparam logic [3:0] OP_LOAD_OUT  = 4'd8;

  // Jump conditions. A step whose condition is false holds its place.
  localparam logic [2:0] COND_ALWAYS    = 3'd0;
  localparam logic [2:0] COND_IN_VALID  = 3'd1;
  localparam logic [2:0] COND_SCAN_DONE = 3'd2;
  localparam logic [2:0] COND_OUT_FREE  = 3'd3;
  localparam logic [2:0] COND_DISPATCH  = 3'd4;

  // Step addresses of the control program.
  localparam logic [UPC_W-1:0] U_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] U_DISP   = 4'd1;
  localparam logic [UPC_W-1:0] U_PUSH_T = 4'd2;
  localparam logic [UPC_W-1:0] U_PUSH_H = 4'd3;
  localparam logic [UPC_W-1:0] U_POP_T  = 4'd4;
  localparam logic [UPC_W-1:0] U_POP_H  = 4'd5;
  localparam logic [UPC_W-1:0] U_TAKE   = 4'd6;
  localparam logic [UPC_W-1:0] U_FULL   = 4'd7;
  localparam logic [UPC_W-1:0] U_EMPTY  = 4'd8;
  localparam logic [UPC_W-1:0] U_FIND   = 4'd9;
  localparam logic [UPC_W-1:0] U_SCAN   = 4'd10;
  localparam logic [UPC_W-1:0] U_FIN    = 4'd11;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
  } dq_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data_out;
    logic [5:0]  position;
    logic [6:0]  count;
  } dq_out_t;

  typedef struct packed {
    logic             accept;
    logic [3:0]       op;
    logic             status_wr;
    logic [2:0]       status_val;
    logic [2:0]       cond;
    logic [UPC_W-1:0] target;
  } dq_ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       empty;
    logic       full;
    logic       scan_done;
    logic       out_free;
  } dq_flags_t;

  function automatic dq_ctrl_t mk_word(input logic accept, input logic [3:0] op,
                                       input logic status_wr,
                                       input logic [2:0] status_val,
                                       input logic [2:0] cond,
                                       input logic [UPC_W-1:0] target);
    dq_ctrl_t w;
    w.accept     = accept;
    w.op         = op;
    w.status_wr  = status_wr;
    w.status_val = status_val;
    w.cond       = cond;
    w.target     = target;
    return w;
  endfunction

  // The control program, one word per step.
  function automatic dq_ctrl_t ucode_rom(input logic [UPC_W-1:0] upc);
    dq_ctrl_t w;
    case (upc)
      U_IDLE:   w = mk_word(1'b1, OP_NONE, 1'b0, ST_DONE, COND_IN_VALID, U_DISP);
      U_DISP:   w = mk_word(1'b0, OP_CLEAR, 1'b0, ST_DONE, COND_DISPATCH, U_IDLE);
      U_PUSH_T: w = mk_word(1'b0, OP_PUSH_TAIL, 1'b0, ST_DONE, COND_ALWAYS, U_FIN);
      U_PUSH_H: w = mk_word(1'b0, OP_PUSH_HEAD, 1'b0, ST_DONE, COND_ALWAYS, U_FIN);
      U_POP_T:  w = mk_word(1'b0, OP_READ_TAIL, 1'b0, ST_DONE, COND_ALWAYS, U_TAKE);
      U_POP_H:  w = mk_word(1'b0, OP_READ_HEAD, 1'b0, ST_DONE, COND_ALWAYS, U_TAKE);
      U_TAKE:   w = mk_word(1'b0, OP_TAKE, 1'b0, ST_DONE, COND_ALWAYS, U_FIN);
      U_FULL:   w = mk_word(1'b0, OP_NONE, 1'b1, ST_FULL, COND_ALWAYS, U_FIN);
      U_EMPTY:  w = mk_word(1'b0, OP_NONE, 1'b1, ST_EMPTY, COND_ALWAYS, U_FIN);
      U_FIND:   w = mk_word(1'b0, OP_NONE, 1'b1, ST_MISS, COND_ALWAYS, U_SCAN);
      U_SCAN:   w = mk_word(1'b0, OP_SCAN, 1'b0, ST_DONE, COND_SCAN_DONE, U_FIN);
      U_FIN:    w = mk_word(1'b0, OP_LOAD_OUT, 1'b0, ST_DONE, COND_OUT_FREE, U_IDLE);
      default:  w = mk_word(1'b0, OP_NONE, 1'b0, ST_DONE, COND_ALWAYS, U_IDLE);
    endcase
    return w;
  endfunction

  // Entry point of each command's routine.
  function automatic logic [UPC_W-1:0] dispatch(input logic [2:0] cmd,
                                                input logic empty, input logic full);
    logic [UPC_W-1:0] t;
    case (cmd)
      CMD_PUSH_TAIL: t = full ? U_FULL : U_PUSH_T;
      CMD_POP_TAIL:  t = empty ? U_EMPTY : U_POP_T;
      CMD_PUSH_HEAD: t = full ? U_FULL : U_PUSH_H;
      CMD_POP_HEAD:  t = empty ? U_EMPTY : U_POP_H;
      CMD_FIND:      t = U_FIND;
      default:       t = U_FIN;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== src/bounded_deque_with_search.sv =====
// Bounded double-ended queue with linear search: top level.
// Usage: each input transaction carries a command (push tail, pop tail, push head,
// pop head, find) and a data word; each one yields exactly one result transaction
// with a status, the popped word, the find position and the count held afterward.
// Commands are taken one at a time: in_stall is low only while the sequencer waits
// in its idle step out of reset. An accepted command passes through the dispatch step,
// its routine (a store for a push, a read and a take for a pop, a status write for a
// rejected command, the scan for a find, none for an unused code) and the final step,
// which loads the result. The search fetches one entry per cycle from the entry store
// while comparing the previous one. The next command is accepted in the cycle after
// the result is loaded.
// A finished result sits in the output register; the block takes the next command
// while it waits, and only holds its final step if a new result is ready while the
// old one is still stalled. Reset empties the queue, holds in_stall high and clears
// the output valid; the entry store itself needs no clearing.
`default_nettype none
module bounded_deque_with_search #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire dq_pkg::dq_in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dq_pkg::dq_out_t      out_data
);
  import dq_pkg::*;

  dq_ctrl_t  ctrl;
  dq_flags_t flags;

  assign in_stall = !ctrl.accept || !rst_n;

  dq_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .flags   (flags),
    .ctrl    (ctrl)
  );

  dq_dp #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_valid (in_valid),
    .in_data  (in_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .flags    (flags)
  );

endmodule
`default_nettype wire

// ===== src/dq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/dq_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none
module dq_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire dq_pkg::dq_flags_t flags,
  output dq_pkg::dq_ctrl_t       ctrl
);
  import dq_pkg::*;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic             cond_true;

  assign ctrl = ucode_rom(upc_r);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_IN_VALID:  cond_true = in_valid;
      COND_SCAN_DONE: cond_true = flags.scan_done;
      COND_OUT_FREE:  cond_true = flags.out_free;
      default:        cond_true = 1'b1;
    endcase
    if (ctrl.cond == COND_DISPATCH) begin
      upc_nxt = dispatch(flags.cmd, flags.empty, flags.full);
    end else if (cond_true) begin
      upc_nxt = ctrl.target;
    end else begin
      upc_nxt = upc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/dq_dp.sv =====
// Datapath: ring pointers, entry store, search index and result registers.
`default_nettype none
module dq_dp #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dq_pkg::dq_ctrl_t ctrl,
  input  wire logic             in_valid,
  input  wire dq_pkg::dq_in_t   in_data,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output dq_pkg::dq_out_t       out_data,
  output dq_pkg::dq_flags_t     flags
);
  import dq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  logic [2:0]            cmd_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [IW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         scan_i_r, scan_i_nxt;
  logic                  cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]         cmp_i_r, cmp_i_nxt;
  logic [2:0]            res_status_r, res_status_nxt;
  logic [31:0]           res_data_r, res_data_nxt;
  logic [5:0]            res_pos_r, res_pos_nxt;
  dq_out_t               out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  in_fire;
  logic [SW-1:0]         off, sum, slot;
  logic [IW-1:0]         head_new;
  logic [IW-1:0]         front_inc;
  logic                  wr_en, rd_en;
  logic [IW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  match, scan_end, out_free;

  assign in_fire  = ctrl.accept && in_valid;
  assign match    = cmp_v_r && (rd_data == word_r);
  assign scan_end = (scan_i_r == count_r);
  assign out_free = !out_valid_r || !out_stall;

  assign flags.cmd       = cmd_r;
  assign flags.empty     = (count_r == '0);
  assign flags.full      = (count_r == CW'(DEPTH));
  assign flags.scan_done = match || scan_end;
  assign flags.out_free  = out_free;

  // Ring slot of front plus an offset; the sum stays below twice the depth.
  always_comb begin
    case (ctrl.op)
      OP_PUSH_TAIL: off = SW'(count_r);
      OP_READ_TAIL: off = SW'(count_r) - SW'(1);
      OP_SCAN:      off = SW'(scan_i_r);
      default:      off = '0;
    endcase
    sum  = {1'b0, front_r} + off;
    slot = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
  end

  assign head_new  = (front_r == '0) ? IW'(DEPTH - 1) : (front_r - IW'(1));
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : (front_r + IW'(1));

  assign wr_en   = (ctrl.op == OP_PUSH_TAIL) || (ctrl.op == OP_PUSH_HEAD);
  assign wr_addr = (ctrl.op == OP_PUSH_HEAD) ? head_new : slot[IW-1:0];
  assign rd_addr = slot[IW-1:0];

  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    scan_i_nxt     = scan_i_r;
    cmp_v_nxt      = 1'b0;
    cmp_i_nxt      = cmp_i_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_pos_nxt    = res_pos_r;
    out_nxt        = out_r;
    rd_en          = 1'b0;
    case (ctrl.op)
      OP_CLEAR: begin
        res_status_nxt = ST_DONE;
        res_data_nxt   = '0;
        res_pos_nxt    = '0;
        scan_i_nxt     = '0;
      end
      OP_PUSH_TAIL: begin
        count_nxt = count_r + CW'(1);
      end
      OP_PUSH_HEAD: begin
        front_nxt = head_new;
        count_nxt = count_r + CW'(1);
      end
      OP_READ_TAIL: begin
        rd_en     = 1'b1;
        count_nxt = count_r - CW'(1);
      end
      OP_READ_HEAD: begin
        rd_en     = 1'b1;
        front_nxt = front_inc;
        count_nxt = count_r - CW'(1);
      end
      OP_TAKE: begin
        res_data_nxt = 32'(rd_data);
      end
      OP_SCAN: begin
        // The word read last cycle is compared while the next one is fetched.
        if (match) begin
          res_status_nxt = ST_FOUND;
          res_pos_nxt    = 6'(cmp_i_r);
        end else if (!scan_end) begin
          rd_en      = 1'b1;
          cmp_v_nxt  = 1'b1;
          cmp_i_nxt  = scan_i_r[IW-1:0];
          scan_i_nxt = scan_i_r + CW'(1);
        end
      end
      OP_LOAD_OUT: begin
        if (out_free) begin
          out_nxt.status   = res_status_r;
          out_nxt.data_out = res_data_r;
          out_nxt.position = res_pos_r;
          out_nxt.count    = 7'(count_r);
        end
      end
      default: begin
      end
    endcase
    if (ctrl.status_wr) begin
      res_status_nxt = ctrl.status_val;
    end
    if ((ctrl.op == OP_LOAD_OUT) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_data.cmd;
      word_r <= DATA_WIDTH'(in_data.value);
    end
    scan_i_r     <= scan_i_nxt;
    cmp_i_r      <= cmp_i_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_pos_r    <= res_pos_nxt;
    out_r        <= out_nxt;
  end

  dq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(word_r),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== dv/bounded_deque_with_search_tb.sv =====
// Self-checking testbench for the bounded double-ended queue with linear search.
module bounded_deque_with_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int STUCK_LIMIT = 4000;
  localparam int MAX_GAP     = 40;

  // Command codes the block treats as no operation.
  localparam logic [2:0] CMD_FIRST_UNUSED = CMD_FIND + 3'd1;
  localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

  localparam logic [31:0] WORD_ZERO = 32'h0000_0000;
  localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  dq_in_t  in_data   = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  dq_out_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int stuck_cycles = 0;

  // Shadow copy of the deque contents.
  logic [31:0] shadow_store [DEPTH];
  int          shadow_head = 0;
  int          shadow_held = 0;

  dq_out_t expected_replies [$];
  dq_out_t want_reply;

  bounded_deque_with_search #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [31:0] shadow_word(input int offset);
    return shadow_store[(shadow_head + offset) % DEPTH];
  endfunction

  // Applies one command to the shadow deque and returns the reply it must produce.
  function automatic dq_out_t shadow_deque_step(input dq_in_t item);
    dq_out_t reply;
    reply = '0;
    reply.status = ST_DONE;
    case (item.cmd)
      CMD_PUSH_TAIL: begin
        if (shadow_held >= DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          shadow_store[(shadow_head + shadow_held) % DEPTH] = item.value;
          shadow_held++;
        end
      end
      CMD_POP_TAIL: begin
        if (shadow_held == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.data_out = shadow_word(shadow_held - 1);
          shadow_held--;
        end
      end
      CMD_PUSH_HEAD: begin
        if (shadow_held >= DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_store[shadow_head] = item.value;
          shadow_held++;
        end
      end
      CMD_POP_HEAD: begin
        if (shadow_held == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.data_out = shadow_store[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_held--;
        end
      end
      CMD_FIND: begin
        reply.status = ST_MISS;
        for (int i = 0; i < shadow_held; i++) begin
          if (shadow_word(i) == item.value) begin
            reply.status = ST_FOUND;
            reply.position = 6'(i);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    reply.count = 7'(shadow_held);
    return reply;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Sends one command, with a random gap ahead of it, and records its reply.
  task automatic issue_command(input logic [2:0] cmd, input logic [31:0] value);
    dq_in_t item;
    int gap;
    item.cmd = cmd;
    item.value = value;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_replies.push_back(shadow_deque_step(item));
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      return 32'($urandom_range(7));
    end else if (pick < 35) begin
      return $urandom_range(1) ? WORD_ONES : WORD_ZERO;
    end
    return $urandom;
  endfunction

  task automatic test_directed();
    issue_command(CMD_POP_TAIL, $urandom);
    issue_command(CMD_POP_HEAD, $urandom);
    issue_command(CMD_FIND, WORD_ZERO);
    issue_command(CMD_PUSH_TAIL, WORD_ZERO);
    issue_command(CMD_PUSH_TAIL, WORD_ONES);
    issue_command(CMD_PUSH_HEAD, 32'h8000_0001);
    issue_command(CMD_FIND, WORD_ONES);
    issue_command(CMD_FIND, WORD_ZERO);
    issue_command(CMD_FIND, 32'h7FFF_FFFE);
    for (logic [3:0] c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++) begin
      issue_command(c[2:0], $urandom);
    end
    issue_command(CMD_POP_HEAD, $urandom);
    issue_command(CMD_POP_TAIL, $urandom);
    issue_command(CMD_POP_TAIL, $urandom);
    issue_command(CMD_POP_HEAD, $urandom);
    issue_command(CMD_PUSH_HEAD, 32'h5A5A_A5A5);
    issue_command(CMD_FIND, 32'h5A5A_A5A5);
    issue_command(CMD_POP_TAIL, $urandom);
  endtask

  // Fills the deque from both ends, hits it while full, then empties it again.
  task automatic test_fill_and_empty();
    logic [31:0] tail_word;
    logic [31:0] head_word;
    while (shadow_held < DEPTH) begin
      issue_command($urandom_range(1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD, $urandom);
    end
    issue_command(CMD_PUSH_TAIL, $urandom);
    issue_command(CMD_PUSH_HEAD, $urandom);
    tail_word = shadow_word(DEPTH - 1);
    head_word = shadow_word(0);
    issue_command(CMD_FIND, tail_word);
    issue_command(CMD_FIND, head_word);
    issue_command(CMD_FIND, $urandom);
    while (shadow_held > 0) begin
      issue_command($urandom_range(1) ? CMD_POP_TAIL : CMD_POP_HEAD, $urandom);
    end
    issue_command(CMD_POP_HEAD, $urandom);
  endtask

  // Random traffic in stretches that lean toward filling, draining or neither.
  task automatic test_random_traffic(input int n_items);
    int push_pct;
    int pick;
    logic [31:0] word;
    push_pct = 45;
    for (int k = 0; k < n_items; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 80;
          1: push_pct = 15;
          default: push_pct = 45;
        endcase
      end
      if ($urandom_range(99) == 0) wait_for_replies();
      pick = $urandom_range(99);
      if (pick < push_pct) begin
        issue_command($urandom_range(1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD, random_word());
      end else if (pick < push_pct + 20) begin
        if (shadow_held > 0 && $urandom_range(99) < 60) begin
          word = shadow_word($urandom_range(shadow_held - 1));
        end else begin
          word = random_word();
        end
        issue_command(CMD_FIND, word);
      end else if (pick < push_pct + 23) begin
        issue_command(3'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED)), $urandom);
      end else begin
        issue_command($urandom_range(1) ? CMD_POP_TAIL : CMD_POP_HEAD, $urandom);
      end
    end
  endtask

  task automatic finish_run();
    wait_for_replies();
    repeat (DEPTH + 10) @(posedge clk);
    while (expected_replies.size() != 0) begin
      want_reply = expected_replies.pop_front();
      report_mismatch("missing result, status", 'x, want_reply.status);
    end
    if (mismatch_count == 0) begin
      $display("bounded_deque_with_search_tb passed");
    end else begin
      $display("bounded_deque_with_search_tb failed");
    end
    $finish;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected result, status", out_data.status, 'x);
      end else begin
        want_reply = expected_replies.pop_front();
        if (out_data.status !== want_reply.status)
          report_mismatch("status", out_data.status, want_reply.status);
        if (out_data.data_out !== want_reply.data_out)
          report_mismatch("data_out", out_data.data_out, want_reply.data_out);
        if (out_data.position !== want_reply.position)
          report_mismatch("position", out_data.position, want_reply.position);
        if (out_data.count !== want_reply.count)
          report_mismatch("count", out_data.count, want_reply.count);
      end
    end
  end

  // Ends the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("bounded_deque_with_search_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 85;
    test_directed();
    test_fill_and_empty();
    test_random_traffic(170);
    wait_for_replies();

    send_idle_pct = 85;
    recv_idle_pct = 12;
    test_random_traffic(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(170);

    finish_run();
  end

endmodule
